/* rtl/core/hsvr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsvr_pkg
// Types, register indexes and 8-bit scaling helpers for the rainbow
// HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvr_pkg;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// configuration register indexes
	localparam logic [1:0] REG_YELLOW_STRONG = 2'd0;
	localparam logic [1:0] REG_GREEN_HALVE   = 2'd1;
	localparam logic [1:0] REG_GREEN_SCALE   = 2'd2;

	// hue sections (top three hue bits)
	localparam logic [2:0] SEC_RED_ORANGE    = 3'd0;
	localparam logic [2:0] SEC_ORANGE_YELLOW = 3'd1;
	localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd2;
	localparam logic [2:0] SEC_GREEN_AQUA    = 3'd3;
	localparam logic [2:0] SEC_AQUA_BLUE     = 3'd4;
	localparam logic [2:0] SEC_BLUE_PURPLE   = 3'd5;
	localparam logic [2:0] SEC_PURPLE_PINK   = 3'd6;
	localparam logic [2:0] SEC_PINK_RED      = 3'd7;

	localparam logic [7:0] THIRD_SCALE     = 8'(256 / 3);
	localparam logic [7:0] TWOTHIRDS_SCALE = 8'((256 * 2) / 3);

	// (i * (s + 1)) >> 8
	function automatic logic [7:0] sc8(input logic [7:0] i, input logic [7:0] s);
		logic [16:0] p;
		p = 17'(i) * 17'({1'b0, s} + 9'd1);
		return p[15:8];
	endfunction

	// ((i * s) >> 8) plus one when both operands are nonzero
	function automatic logic [7:0] sc8v(input logic [7:0] i, input logic [7:0] s);
		logic [15:0] p;
		p = 16'(i) * 16'(s);
		return p[15:8] + 8'((i != 8'd0) && (s != 8'd0));
	endfunction

endpackage
`default_nettype wire

/* rtl/core/hsv_to_rgb_rainbow.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_rainbow
// Rainbow HSV to RGB conversion, 8 bits per channel, four register stages.
// A request accepted at a clock edge passes the s1 to s4 registers and shows its
// result with done high from s4. Throughput: one request per cycle; busy stays low.
// Four stages: hue section map, green adjust, desaturation, value scaling.
// Reset clears the stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module hsv_to_rgb_rainbow
	import hsvr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire hsv_t       req,
	output logic            done,
	output rgb_t            rsp,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [7:0] cfg_data
);

	logic       yellow_strong_q;
	logic       green_halve_q;
	logic [7:0] green_scale_q;

	logic       vld_s1, vld_s2, vld_s3, vld_s4;

	assign busy = 1'b0;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yellow_strong_q <= 1'b0;
			green_halve_q   <= 1'b1;
			green_scale_q   <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_YELLOW_STRONG: yellow_strong_q <= cfg_data[0];
				REG_GREEN_HALVE:   green_halve_q   <= cfg_data[0];
				REG_GREEN_SCALE:   green_scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: hue section map, desaturation and value squares
	logic [7:0] off8, third, twothirds, dsat;
	logic [7:0] r_c1, g_c1, b_c1;

	always_comb begin
		off8      = {req.hue[4:0], 3'b000};
		third     = sc8(off8, THIRD_SCALE);
		twothirds = sc8(off8, TWOTHIRDS_SCALE);
		dsat      = 8'd255 - req.saturation;
		r_c1 = 8'd0;
		g_c1 = 8'd0;
		b_c1 = 8'd0;
		case (req.hue[7:5])
			SEC_RED_ORANGE: begin
				r_c1 = 8'd255 - third;
				g_c1 = third;
			end
			SEC_ORANGE_YELLOW: begin
				if (yellow_strong_q) begin
					r_c1 = 8'd170 + third;
					g_c1 = 8'd85 + twothirds;
				end else begin
					r_c1 = 8'd171;
					g_c1 = 8'd85 + third;
				end
			end
			SEC_YELLOW_GREEN: begin
				if (yellow_strong_q) begin
					r_c1 = 8'd255 - off8;
					g_c1 = 8'd255;
				end else begin
					r_c1 = 8'd171 - twothirds;
					g_c1 = 8'd170 + third;
				end
			end
			SEC_GREEN_AQUA: begin
				g_c1 = 8'd255 - third;
				b_c1 = third;
			end
			SEC_AQUA_BLUE: begin
				g_c1 = 8'd171 - twothirds;
				b_c1 = 8'd85 + twothirds;
			end
			SEC_BLUE_PURPLE: begin
				r_c1 = third;
				b_c1 = 8'd255 - third;
			end
			SEC_PURPLE_PINK: begin
				r_c1 = 8'd85 + third;
				b_c1 = 8'd171 - third;
			end
			SEC_PINK_RED: begin
				r_c1 = 8'd170 + third;
				b_c1 = 8'd85 - third;
			end
			default: ;
		endcase
	end

	logic [7:0] r_s1, g_s1, b_s1, desat_s1, valsq_s1;
	logic       sat_full_s1, sat_zero_s1, val_full_s1;

	always_ff @(posedge clk) begin
		r_s1        <= r_c1;
		g_s1        <= g_c1;
		b_s1        <= b_c1;
		desat_s1    <= sc8v(dsat, dsat);
		valsq_s1    <= sc8v(req.brightness, req.brightness);
		sat_full_s1 <= (req.saturation == 8'd255);
		sat_zero_s1 <= (req.saturation == 8'd0);
		val_full_s1 <= (req.brightness == 8'd255);
	end

	// stage 2: green halve and scale
	logic [7:0] g_half;
	assign g_half = green_halve_q ? {1'b0, g_s1[7:1]} : g_s1;

	logic [7:0] r_s2, g_s2, b_s2, desat_s2, valsq_s2;
	logic       sat_full_s2, sat_zero_s2, val_full_s2;

	always_ff @(posedge clk) begin
		r_s2        <= r_s1;
		g_s2        <= (green_scale_q != 8'd0) ? sc8v(g_half, green_scale_q) : g_half;
		b_s2        <= b_s1;
		desat_s2    <= desat_s1;
		valsq_s2    <= valsq_s1;
		sat_full_s2 <= sat_full_s1;
		sat_zero_s2 <= sat_zero_s1;
		val_full_s2 <= val_full_s1;
	end

	// stage 3: desaturation
	logic [7:0] satscale;
	assign satscale = 8'd255 - desat_s2;

	logic [7:0] r_s3, g_s3, b_s3, valsq_s3;
	logic       val_full_s3;

	always_ff @(posedge clk) begin
		if (sat_full_s2) begin
			r_s3 <= r_s2;
			g_s3 <= g_s2;
			b_s3 <= b_s2;
		end else if (sat_zero_s2) begin
			r_s3 <= 8'd255;
			g_s3 <= 8'd255;
			b_s3 <= 8'd255;
		end else begin
			r_s3 <= sc8(r_s2, satscale) + desat_s2;
			g_s3 <= sc8(g_s2, satscale) + desat_s2;
			b_s3 <= sc8(b_s2, satscale) + desat_s2;
		end
		valsq_s3    <= valsq_s2;
		val_full_s3 <= val_full_s2;
	end

	// stage 4: value scaling into the result register
	rgb_t rsp_s4;

	always_ff @(posedge clk) begin
		if (val_full_s3) begin
			rsp_s4.red   <= r_s3;
			rsp_s4.green <= g_s3;
			rsp_s4.blue  <= b_s3;
		end else if (valsq_s3 == 8'd0) begin
			rsp_s4 <= '0;
		end else begin
			rsp_s4.red   <= sc8(r_s3, valsq_s3);
			rsp_s4.green <= sc8(g_s3, valsq_s3);
			rsp_s4.blue  <= sc8(b_s3, valsq_s3);
		end
	end

	assign done = vld_s4;
	assign rsp  = rsp_s4;

`ifndef NO_ASSERTIONS
	a_done_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done)
		else $error("request did not complete in four cycles");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without a request");

	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		(start && req.saturation == 8'd0 && req.brightness == 8'd255) |-> ##4 (rsp == '1))
		else $error("zero saturation at full value is not white");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(start && req.brightness == 8'd0) |-> ##4 (rsp == '0))
		else $error("zero value is not black");
`endif

endmodule
`default_nettype wire
